[design/mh2_pkg.sv]
// shared constants, types and helpers for the murmurhash2 stream unit
// no dependencies; compile first
package mh2_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;

  localparam logic [WordW-1:0] MixMul = 32'h5bd1e995;

  localparam int unsigned MixShift  = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // accept an item, fold it into the running hash
    logic mix;    // second half of a full-word mix
    logic fin_a;  // xor-shift 13 and multiply
    logic fin_b;  // xor-shift 15 into the output register
  } mh2_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic item_full;  // offered item carries a full word
    logic item_last;  // offered item ends the string
    logic last_q;     // item in flight ends the string
  } mh2_status_t;

  // keeps the low byte_count bytes of a short tail word
  function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] count);
    logic [WordW-1:0] mask;
    case (count)
      3'd1: mask = 32'h0000_00ff;
      3'd2: mask = 32'h0000_ffff;
      3'd3: mask = 32'h00ff_ffff;
      default: mask = '0;
    endcase
    return mask;
  endfunction

endpackage

[design/mh2_if.sv]
// valid/ready channel interfaces for the murmurhash2 stream unit
// depends on mh2_pkg
interface mh2_item_if;
  logic                          valid;
  logic                          ready;
  logic [mh2_pkg::WordW-1:0]     data_word;
  logic [mh2_pkg::CountW-1:0]    byte_count;
  logic [mh2_pkg::WordW-1:0]     total_length;
  logic                          last_item;

  modport source (
    output valid, data_word, byte_count, total_length, last_item,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, total_length, last_item,
    output ready
  );
endinterface

interface mh2_hash_if;
  logic                      valid;
  logic                      ready;
  logic [mh2_pkg::WordW-1:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

[design/mh2_datapath.sv]
// hash datapath: running hash, word mixing, tail folding and finalization
// depends on mh2_pkg
module mh2_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mh2_pkg::mh2_cmd_t          cmd_i,
  output mh2_pkg::mh2_status_t       status_o,
  input  logic [mh2_pkg::WordW-1:0]  data_word_i,
  input  logic [mh2_pkg::CountW-1:0] byte_count_i,
  input  logic [mh2_pkg::WordW-1:0]  total_length_i,
  input  logic                       last_item_i,
  output logic [mh2_pkg::WordW-1:0]  hash_value_o
);

  logic                      mid_q;
  logic                      last_q;
  logic [mh2_pkg::WordW-1:0] h_q;
  logic [mh2_pkg::WordW-1:0] k_q;
  logic [mh2_pkg::WordW-1:0] hash_q;

  logic                      item_full;
  logic [mh2_pkg::WordW-1:0] start;
  logic [mh2_pkg::WordW-1:0] h_op;
  logic [mh2_pkg::WordW-1:0] h_prod;
  logic [mh2_pkg::WordW-1:0] k_prod;

  // counts 4 to 7 count as a full word
  assign item_full = byte_count_i[mh2_pkg::CountW-1];

  // a new string seeds the hash with its length
  assign start = mid_q ? h_q : total_length_i;

  always_comb begin
    if (cmd_i.load) begin
      h_op = item_full ? start
                       : (start ^ (data_word_i & mh2_pkg::tail_mask(byte_count_i)));
    end else if (cmd_i.mix) begin
      h_op = k_q ^ (k_q >> mh2_pkg::MixShift);
    end else begin
      h_op = h_q ^ (h_q >> mh2_pkg::FinShiftA);
    end
  end

  // products keep the low 32 bits
  assign h_prod = h_op * mh2_pkg::MixMul;
  assign k_prod = data_word_i * mh2_pkg::MixMul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (cmd_i.load) begin
      mid_q <= !last_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q    <= k_prod;
      last_q <= last_item_i;
      if (byte_count_i == '0) begin
        h_q <= start;
      end else begin
        // full word: h*M now, k mixed in next cycle; tail: (h^tail)*M
        h_q <= h_prod;
      end
    end else if (cmd_i.mix) begin
      h_q <= h_q ^ h_prod;
    end else if (cmd_i.fin_a) begin
      h_q <= h_prod;
    end
    if (cmd_i.fin_b) begin
      hash_q <= h_q ^ (h_q >> mh2_pkg::FinShiftB);
    end
  end

  assign status_o.item_full = item_full;
  assign status_o.item_last = last_item_i;
  assign status_o.last_q    = last_q;
  assign hash_value_o       = hash_q;

endmodule

[design/mh2_ctrl.sv]
// controller: sequences item intake, word mixing, finalization and output
// depends on mh2_pkg
module mh2_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mh2_pkg::mh2_status_t status_i,
  output mh2_pkg::mh2_cmd_t    cmd_o,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  typedef enum logic [1:0] {
    StIdle,
    StMix,
    StFinA,
    StFinB
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == StIdle);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.mix   = (state_q == StMix);
  assign cmd_o.fin_a = (state_q == StFinA);
  // output register frees up when its transaction completes
  assign cmd_o.fin_b = (state_q == StFinB) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.load) begin
            if (status_i.item_full) begin
              state_q <= StMix;
            end else if (status_i.item_last) begin
              state_q <= StFinA;
            end
          end
        end
        StMix: begin
          state_q <= status_i.last_q ? StFinA : StIdle;
        end
        StFinA: begin
          state_q <= StFinB;
        end
        StFinB: begin
          if (cmd_o.fin_b) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase

      if (cmd_o.fin_b) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[design/murmurhash2_32_stream_unit.sv]
// top level of the murmurhash2 stream unit: controller plus datapath
// depends on mh2_pkg, mh2_if, mh2_ctrl and mh2_datapath
//
// Computes the 32-bit MurmurHash2 (seed zero) of a byte string that arrives as
// little-endian 32-bit words; the first item of a string seeds the hash with
// total_length and the item marked last produces one hash transaction. A full
// word passes an intake step and then a mix step (set by the two dependent
// constant multiplies on k), a tail or empty word needs only the intake step,
// and a last item then adds the finalization steps fin_a (on the shared
// multiplier) and fin_b before the result enters the output register. A new
// item is taken while a finished hash still waits in the output register;
// finalization of the next string waits until that register is free.
module murmurhash2_32_stream_unit (
  input  logic clk_i,
  input  logic rst_ni,
  mh2_item_if.sink   item_i,
  mh2_hash_if.source hash_o
);

  mh2_pkg::mh2_cmd_t    cmd;
  mh2_pkg::mh2_status_t status;

  mh2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (hash_o.valid),
    .out_ready_i (hash_o.ready)
  );

  mh2_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_word_i    (item_i.data_word),
    .byte_count_i   (item_i.byte_count),
    .total_length_i (item_i.total_length),
    .last_item_i    (item_i.last_item),
    .hash_value_o   (hash_o.hash_value)
  );

`ifndef SYNTH
  // a short last item goes straight into finalization
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && item_i.last_item && !item_i.byte_count[2])
    |=> !item_i.ready)
    else $error("short last item did not start finalization");

  // a short item mid-string completes in its intake cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && !item_i.last_item && !item_i.byte_count[2])
    |=> item_i.ready)
    else $error("short item mid-string stalled the input");

  // a full word always takes a mix step after its intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && item_i.byte_count[2])
    |=> !item_i.ready)
    else $error("full word accepted without a mix cycle");

  // a new hash only appears out of the busy finalization step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_o.valid) |-> $past(!item_i.ready))
    else $error("hash transaction raised while input side was idle");
`endif

endmodule
